// File: rtl/core/rdc_pkg.sv
// Shared types, sizes and the digit character map for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

    // Sizes
    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_ADDR_W = $clog2(MAX_DIGITS);
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

    // Radix limits
    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    // Input word
    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  base;
    } rdc_in_t;

    // Result word
    typedef struct packed {
        logic [6:0] digit_char;
        logic       is_last;
        logic       bad_base;
    } rdc_out_t;

    // Map a 4-bit digit to upper-case ASCII
    function automatic logic [6:0] digit_to_char(input logic [3:0] digit);
        logic [6:0] ext;
        ext = {3'b000, digit};
        if (digit < 4'd10) begin
            digit_to_char = 7'h30 + ext;
        end else begin
            digit_to_char = 7'h37 + ext;
        end
    endfunction

endpackage

// File: rtl/core/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when not enabled
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/radix_digit_converter_unit.sv
// Top level: integer to base-2..16 ASCII digit converter with a shared bit-serial divider.
//
//  Channel | Ports                        | Dir | Word
//  --------+------------------------------+-----+------------------------------------
//  s_      | s_valid, s_ready, s_data     | in  | value (32b), base (5b)
//  m_      | m_valid, m_ready, m_data     | out | digit_char (7b), is_last, bad_base
//
//  One restoring divider, one quotient bit a cycle, finds each digit in turn.
//  s_ready is high only between words; the last digit may still wait in the output register.
//  A stalled m_ready holds digit readout; reset is synchronous, active low, and clears control.
`timescale 1ns / 1ps

module radix_digit_converter_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rdc_pkg::rdc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rdc_pkg::rdc_out_t m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;

    localparam int VB = rdc_pkg::VALUE_BITS;
    localparam int AW = rdc_pkg::DIGIT_ADDR_W;
    localparam int CW = rdc_pkg::BIT_CNT_W;

    logic [2:0]    state_reg, state_next;
    logic [VB-1:0] quot_reg, quot_next;
    logic [3:0]    rem_reg, rem_next;
    logic [4:0]    base_reg, base_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [AW-1:0] digit_idx_reg, digit_idx_next;

    logic              m_valid_reg, m_valid_next;
    rdc_pkg::rdc_out_t m_data_reg, m_data_next;

    logic [4:0]    trial;
    logic          trial_ge;
    logic [4:0]    trial_diff;
    logic [3:0]    rem_new;
    logic [VB-1:0] quot_new;
    logic          bit_last;
    logic          slot_free;
    logic          ram_we;
    logic          ram_re;
    logic [3:0]    ram_rdata;
    logic          in_fire;
    logic          base_bad;

    // Divider step: bring the next quotient bit into the partial remainder
    assign trial      = {rem_reg, quot_reg[VB-1]};
    assign trial_ge   = (trial >= base_reg);
    assign trial_diff = trial - base_reg;
    assign rem_new    = trial_ge ? trial_diff[3:0] : trial[3:0];
    assign quot_new   = {quot_reg[VB-2:0], trial_ge};
    assign bit_last   = (bit_cnt_reg == CW'(VB - 1));

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign base_bad  = (s_data.base < rdc_pkg::BASE_MIN) || (s_data.base > rdc_pkg::BASE_MAX);
    assign slot_free = !m_valid_reg || m_ready;
    assign ram_we    = (state_reg == ST_DIV) && bit_last;
    assign ram_re    = (state_reg == ST_RD);

    // Digit store, least significant digit at address zero
    rdc_ram #(
        .WIDTH (4),
        .DEPTH (rdc_pkg::MAX_DIGITS)
    ) u_digit_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (digit_idx_reg),
        .wdata (rem_new),
        .re    (ram_re),
        .raddr (digit_idx_reg),
        .rdata (ram_rdata)
    );

    // Sequencer: divide per digit, then read digits back from the top index down; a bad base gives one error word
    always_comb begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        bit_cnt_next   = bit_cnt_reg;
        digit_idx_next = digit_idx_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // Drop the output word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    quot_next      = VB'(s_data.value);
                    rem_next       = 4'd0;
                    base_next      = s_data.base;
                    bit_cnt_next   = '0;
                    digit_idx_next = '0;
                    state_next     = base_bad ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV: begin
                quot_next    = quot_new;
                rem_next     = rem_new;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_last) begin
                    rem_next     = 4'd0;
                    bit_cnt_next = '0;
                    // Stop on zero quotient or a full store; the index then points at the top digit
                    if (quot_new == '0 || digit_idx_reg == AW'(rdc_pkg::MAX_DIGITS - 1)) begin
                        state_next = ST_RD;
                    end else begin
                        digit_idx_next = digit_idx_reg + 1'b1;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                // Hold the read data until the output register frees up
                if (slot_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.digit_char = rdc_pkg::digit_to_char(ram_rdata);
                    m_data_next.is_last    = (digit_idx_reg == '0);
                    m_data_next.bad_base   = 1'b0;
                    if (digit_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        digit_idx_next = digit_idx_reg - 1'b1;
                        state_next     = ST_RD;
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.digit_char = 7'd0;
                    m_data_next.is_last    = 1'b1;
                    m_data_next.bad_base   = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        base_reg      <= base_next;
        bit_cnt_reg   <= bit_cnt_next;
        digit_idx_reg <= digit_idx_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/rdc_checker.sv
// Port-level checker for the radix digit converter, bound to the top level.
`timescale 1ns / 1ps

module rdc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input rdc_pkg::rdc_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input rdc_pkg::rdc_out_t m_data
);

    // A stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // An accepted word blocks the input for at least the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accepting a word");

    // An error word is a lone, closing word with a zero character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_base |-> m_data.is_last && (m_data.digit_char == 7'd0))
        else $error("malformed error word");

    // A digit word carries an upper-case hex character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bad_base |->
            (m_data.digit_char >= 7'h30 && m_data.digit_char <= 7'h39) ||
            (m_data.digit_char >= 7'h41 && m_data.digit_char <= 7'h46))
        else $error("digit character out of range");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/sv/tb_radix_digit_converter_unit.sv
// Self-checking testbench for the radix digit converter: directed table, then random words.
`timescale 1ns / 1ps

module tb_radix_digit_converter_unit;

    localparam int RANDOM_WORDS  = 245;
    localparam int DIRECTED_ROWS = 25;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 60;

    // Characters typed into the directed table
    localparam logic [6:0] CHAR_NONE = 7'h00;
    localparam logic [6:0] CHAR_0    = 7'h30;
    localparam logic [6:0] CHAR_1    = 7'h31;
    localparam logic [6:0] CHAR_9    = 7'h39;
    localparam logic [6:0] CHAR_F    = 7'h46;

    // Digit glyphs, first character in the top byte
    localparam logic [127:0] GLYPHS = "0123456789ABCDEF";

    typedef struct {
        logic [31:0]       value;
        logic [4:0]        base;
        bit                typed;
        rdc_pkg::rdc_out_t known;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    rdc_pkg::rdc_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    rdc_pkg::rdc_out_t m_data;

    // Expected digit words, oldest first
    rdc_pkg::rdc_out_t pending_digits[$];
    int                mismatch_count;
    bit                quiet;
    bit                hold_start;
    stim_row_t         directed_rows[DIRECTED_ROWS];

    // Converter state mirrored by the predictor
    logic [3:0]  remainder_store[rdc_pkg::MAX_DIGITS];
    logic [31:0] quotient_now;
    int          digits_held;

    radix_digit_converter_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Divide down by the base and list the digits, most significant first; a bad base lists one error word
    function automatic void convert_value(input rdc_pkg::rdc_in_t word,
                                          ref rdc_pkg::rdc_out_t digits[$]);
        logic [63:0]       masked;
        logic [31:0]       radix;
        rdc_pkg::rdc_out_t res;
        int                idx;
        masked = {32'd0, word.value} & ((64'd1 << rdc_pkg::VALUE_BITS) - 64'd1);
        radix = {27'd0, word.base};
        digits = {};
        if (word.base < rdc_pkg::BASE_MIN || word.base > rdc_pkg::BASE_MAX) begin
            digits_held = 0;
            res.digit_char = CHAR_NONE;
            res.is_last = 1'b1;
            res.bad_base = 1'b1;
            digits.push_back(res);
            return;
        end
        quotient_now = masked[31:0];
        digits_held = 0;
        do begin
            remainder_store[digits_held] = 4'(quotient_now % radix);
            digits_held++;
            quotient_now = quotient_now / radix;
        end while (quotient_now != 0 && digits_held < rdc_pkg::MAX_DIGITS);
        quotient_now = '0;
        for (int k = 0; k < digits_held; k++) begin
            idx = digits_held - 1 - k;
            res.digit_char = GLYPHS[8 * (15 - int'(remainder_store[idx])) +: 7];
            res.is_last = (k + 1 == digits_held);
            res.bad_base = 1'b0;
            digits.push_back(res);
        end
    endfunction

    // Offer one word, hold it until accepted, then queue what it should produce
    task automatic offer_word(input rdc_pkg::rdc_in_t word, input bit typed,
                              input rdc_pkg::rdc_out_t known);
        rdc_pkg::rdc_out_t digits[$];
        while (!quiet && $urandom_range(0, 99) < 9) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = word;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        convert_value(word, digits);
        if (typed) begin
            pending_digits.push_back(known);
        end else begin
            foreach (digits[i]) pending_digits.push_back(digits[i]);
        end
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain_results();
        s_valid = 1'b0;
        while (pending_digits.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic rdc_pkg::rdc_in_t random_word();
        rdc_pkg::rdc_in_t word;
        logic [63:0]      power;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            word.base = 5'($urandom_range(2, 16));
        end else if (pick < 92) begin
            word.base = 5'($urandom_range(0, 1));
        end else begin
            word.base = 5'($urandom_range(17, 31));
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            word.value = $urandom;
        end else if (pick < 60) begin
            word.value = $urandom_range(0, 1000);
        end else if (pick < 80) begin
            // land on a digit-count boundary: a power of the base, or one below
            power = 64'd1;
            repeat ($urandom_range(1, 32)) begin
                if (power * word.base <= 64'hFFFF_FFFF && word.base >= rdc_pkg::BASE_MIN) begin
                    power = power * word.base;
                end
            end
            word.value = power[31:0] - 32'($urandom_range(0, 1));
        end else if (pick < 88) begin
            word.value = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        end else begin
            word.value = $urandom & $urandom;
        end
        return word;
    endfunction

    // Drive m_ready: one long hold-off once started, otherwise random stalls except while quiet
    int hold_left;
    bit hold_taken;
    always @(negedge aclk) begin
        if (hold_start && !hold_taken) begin
            hold_left = LONG_HOLD;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    // Compare each accepted digit word with the oldest expectation
    always @(posedge aclk) begin
        rdc_pkg::rdc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_digits.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word: expected none, got char %h last %b bad %b",
                         $time, m_data.digit_char, m_data.is_last, m_data.bad_base);
            end else begin
                want = pending_digits.pop_front();
                if (m_data.digit_char !== want.digit_char || m_data.is_last !== want.is_last
                        || m_data.bad_base !== want.bad_base) begin
                    mismatch_count++;
                    $display("%0t: expected %h last %b bad %b, got %h last %b bad %b",
                             $time, want.digit_char, want.is_last, want.bad_base,
                             m_data.digit_char, m_data.is_last, m_data.bad_base);
                end
            end
        end
    end

    // Hard stop for a hung run
    initial begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        rdc_pkg::rdc_in_t word;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        quiet = 1'b0;
        hold_start = 1'b0;
        quotient_now = '0;
        digits_held = 0;

        // value, base, typed, known result
        directed_rows = '{
            '{32'd0,          5'd10, 1'b1, '{CHAR_0,    1'b1, 1'b0}},
            '{32'd0,          5'd2,  1'b1, '{CHAR_0,    1'b1, 1'b0}},
            '{32'd0,          5'd16, 1'b1, '{CHAR_0,    1'b1, 1'b0}},
            '{32'd0,          5'd0,  1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
            '{32'd5,          5'd1,  1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
            '{32'hFFFF_FFFF,  5'd17, 1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
            '{32'd123,        5'd31, 1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
            '{32'hFFFF_FFFF,  5'd0,  1'b1, '{CHAR_NONE, 1'b1, 1'b1}},
            '{32'd1,          5'd2,  1'b1, '{CHAR_1,    1'b1, 1'b0}},
            '{32'd15,         5'd16, 1'b1, '{CHAR_F,    1'b1, 1'b0}},
            '{32'd9,          5'd10, 1'b1, '{CHAR_9,    1'b1, 1'b0}},
            '{32'hFFFF_FFFF,  5'd2,  1'b0, '0},
            '{32'h8000_0000,  5'd2,  1'b0, '0},
            '{32'hFFFF_FFFF,  5'd16, 1'b0, '0},
            '{32'hFFFF_FFFF,  5'd10, 1'b0, '0},
            '{32'hFFFF_FFFF,  5'd3,  1'b0, '0},
            '{32'd10,         5'd10, 1'b0, '0},
            '{32'd255,        5'd16, 1'b0, '0},
            '{32'hABCD_EF01,  5'd16, 1'b0, '0},
            '{32'h1234_5678,  5'd7,  1'b0, '0},
            '{32'd35,         5'd12, 1'b0, '0},
            '{32'hAAAA_AAAA,  5'd13, 1'b0, '0},
            '{32'h5555_5555,  5'd11, 1'b0, '0},
            '{32'hFFFF_FFFE,  5'd4,  1'b0, '0},
            '{32'd1000,       5'd5,  1'b0, '0}
        };

        // hold reset, release at a falling edge
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // walk the directed table
        foreach (directed_rows[i]) begin
            word.value = directed_rows[i].value;
            word.base = directed_rows[i].base;
            offer_word(word, directed_rows[i].typed, directed_rows[i].known);
        end
        drain_results();

        // random words with one long receiver hold-off, a quiet stretch and one pause
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == 60) hold_start = 1'b1;
            quiet = (i >= 120 && i < 170);
            if (i == 200) drain_results();
            offer_word(random_word(), 1'b0, '0);
        end
        quiet = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
